### hw/rtl/slwd_pkg.sv
// shared types and constants of the sync/length word deframer
// used by the channel interfaces, the top level and its checker; no dependencies
package slwd_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned OVH_W  = 8;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned CFG_IDX_W = 2;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_A   = 2'd0,
        CFG_SYNC_B   = 2'd1,
        CFG_OVERHEAD = 2'd2,
        CFG_MAX_WORDS = 2'd3
    } t_cfg_idx;

    // reset values of the configuration registers
    localparam logic [WORD_W-1:0] SYNC_A_RST    = '0;
    localparam logic [WORD_W-1:0] SYNC_B_RST    = '0;
    localparam logic [OVH_W-1:0]  OVERHEAD_RST  = 8'd2;
    localparam logic [CNT_W-1:0]  MAX_WORDS_RST = 16'hFFFF;

    // shortest frame: sync word plus length word
    localparam logic [CNT_W-1:0]  MIN_FRAME_WORDS = 16'd2;

endpackage

### hw/rtl/slwd_byte_if.sv
// byte channel into the deframer: valid/ready handshake and one raw byte
// depends on slwd_pkg
interface slwd_byte_if;
    logic                         valid;
    logic                         ready;
    logic [slwd_pkg::BYTE_W-1:0]  in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink   (input valid, input in_byte, output ready);
endinterface

### hw/rtl/slwd_word_if.sv
// frame word channel out of the deframer: valid/ready handshake and word marks
// depends on slwd_pkg
interface slwd_word_if;
    logic                         valid;
    logic                         ready;
    logic [slwd_pkg::WORD_W-1:0]  frame_word;
    logic                         first_word;
    logic                         last_word;
    logic                         sync_kind;
    logic                         cut_error;

    modport source (output valid, output frame_word, output first_word,
                    output last_word, output sync_kind, output cut_error,
                    input ready);
    modport sink   (input valid, input frame_word, input first_word,
                    input last_word, input sync_kind, input cut_error,
                    output ready);
endinterface

### hw/rtl/sync_length_word_deframer.sv
// sync/length word deframer: packs bytes into little-endian words and frames them
// depends on slwd_pkg, slwd_byte_if and slwd_word_if
//
// The block takes one byte per cycle and gathers four bytes into a 32-bit word,
// first byte in bits 7..0. While hunting, words that match neither sync pattern
// are dropped. A match opens a frame (kind 0 for pattern a, which wins when both
// match, kind 1 for pattern b); the next word is a byte length and the frame
// holds length/4 + overhead_words words, sync and length words included, at
// least 2 and at most max_frame_words (itself at least 2). A frame cut at the
// maximum carries cut_error on its last word. Every frame word leaves on the
// output channel with first/last marks. One byte is accepted per cycle; the
// only wait comes on the fourth byte of a word while the output register still
// holds an untaken word. A word is on the output in the cycle after its last
// byte is accepted. Configuration is taken on any cycle with i_cfg_we high and
// should be changed only while no frame is in progress; a frame's length is
// fixed when its length word arrives.
module sync_length_word_deframer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    slwd_byte_if.sink                         i_byte,
    slwd_word_if.source                       o_word,
    input  logic                              i_cfg_we,
    input  logic [slwd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [slwd_pkg::WORD_W-1:0]       i_cfg_data
);

    localparam int unsigned TOT_W = slwd_pkg::WORD_W - 1;

    typedef enum logic [1:0] {
        PH_HUNT   = 2'd0,
        PH_LENGTH = 2'd1,
        PH_BODY   = 2'd2
    } t_phase;

    // configuration registers
    logic [slwd_pkg::WORD_W-1:0]  r_sync_a;
    logic [slwd_pkg::WORD_W-1:0]  r_sync_b;
    logic [slwd_pkg::OVH_W-1:0]   r_overhead;
    logic [slwd_pkg::CNT_W-1:0]   r_max_words;

    // word assembly and frame state
    logic [1:0]                   r_lane;
    logic [23:0]                  r_partial;
    t_phase                       r_phase, n_phase;
    logic [slwd_pkg::CNT_W-1:0]   r_words_left, n_words_left;
    logic                         r_kind, n_kind;
    logic                         r_cut, n_cut;

    // output register
    logic                         r_out_valid;
    logic [slwd_pkg::WORD_W-1:0]  r_out_word;
    logic                         r_out_first, r_out_last, r_out_kind, r_out_cut;
    logic                         n_emit, n_first, n_last, n_out_cut;

    logic                         accept;
    logic                         word_done;
    logic [slwd_pkg::WORD_W-1:0]  word;

    // length word arithmetic
    logic [TOT_W-1:0]             total_raw;
    logic [TOT_W-1:0]             total_min;
    logic [slwd_pkg::CNT_W-1:0]   max_eff;
    logic                         too_long;
    logic [slwd_pkg::CNT_W-1:0]   total_words;
    logic [slwd_pkg::CNT_W-1:0]   body_left;

    // bytes of lanes 0..2 never produce a word, so they pass even when the
    // output register is full
    assign i_byte.ready = (r_lane != 2'd3) || !r_out_valid || o_word.ready;
    assign accept       = i_byte.valid && i_byte.ready;
    assign word_done    = accept && (r_lane == 2'd3);
    assign word         = {i_byte.in_byte, r_partial};

    // frame total from the length word, clamped to [2, max]
    always_comb begin
        total_raw = {1'b0, word[slwd_pkg::WORD_W-1:2]} + TOT_W'(r_overhead);
        total_min = (total_raw < TOT_W'(slwd_pkg::MIN_FRAME_WORDS))
                  ? TOT_W'(slwd_pkg::MIN_FRAME_WORDS) : total_raw;
        max_eff   = (r_max_words < slwd_pkg::MIN_FRAME_WORDS)
                  ? slwd_pkg::MIN_FRAME_WORDS : r_max_words;
        too_long  = total_min > TOT_W'(max_eff);
        // not too long means total_min fits in the count width
        total_words = too_long ? max_eff : total_min[slwd_pkg::CNT_W-1:0];
        body_left   = total_words - slwd_pkg::MIN_FRAME_WORDS;
    end

    // per-word frame decisions
    always_comb begin
        n_phase      = r_phase;
        n_words_left = r_words_left;
        n_kind       = r_kind;
        n_cut        = r_cut;
        n_emit       = 1'b0;
        n_first      = 1'b0;
        n_last       = 1'b0;
        n_out_cut    = 1'b0;
        unique case (r_phase)
            PH_LENGTH: begin
                n_emit       = 1'b1;
                n_cut        = too_long;
                n_words_left = body_left;
                if (body_left == '0) begin
                    n_phase   = PH_HUNT;
                    n_last    = 1'b1;
                    n_out_cut = too_long;
                end else begin
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                n_emit       = 1'b1;
                n_words_left = r_words_left - 1'b1;
                if (n_words_left == '0) begin
                    n_phase   = PH_HUNT;
                    n_last    = 1'b1;
                    n_out_cut = r_cut;
                end
            end
            default: begin
                // hunting, and the unused phase code behaves the same
                n_phase = PH_HUNT;
                if (word == r_sync_a || word == r_sync_b) begin
                    n_emit       = 1'b1;
                    n_first      = 1'b1;
                    n_kind       = (word == r_sync_a) ? 1'b0 : 1'b1;
                    n_cut        = 1'b0;
                    n_words_left = '0;
                    n_phase      = PH_LENGTH;
                end
            end
        endcase
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_a    <= slwd_pkg::SYNC_A_RST;
            r_sync_b    <= slwd_pkg::SYNC_B_RST;
            r_overhead  <= slwd_pkg::OVERHEAD_RST;
            r_max_words <= slwd_pkg::MAX_WORDS_RST;
        end else if (i_cfg_we) begin
            unique case (slwd_pkg::t_cfg_idx'(i_cfg_idx))
                slwd_pkg::CFG_SYNC_A:    r_sync_a    <= i_cfg_data;
                slwd_pkg::CFG_SYNC_B:    r_sync_b    <= i_cfg_data;
                slwd_pkg::CFG_OVERHEAD:
                    r_overhead  <= i_cfg_data[slwd_pkg::OVH_W-1:0];
                slwd_pkg::CFG_MAX_WORDS:
                    r_max_words <= i_cfg_data[slwd_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // byte assembly, frame state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane       <= '0;
            r_partial    <= '0;
            r_phase      <= PH_HUNT;
            r_words_left <= '0;
            r_kind       <= 1'b0;
            r_cut        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_lane <= r_lane + 2'd1;
                unique case (r_lane)
                    2'd0:    r_partial[7:0]   <= i_byte.in_byte;
                    2'd1:    r_partial[15:8]  <= i_byte.in_byte;
                    2'd2:    r_partial[23:16] <= i_byte.in_byte;
                    default: r_partial        <= '0;
                endcase
            end
            if (word_done) begin
                r_phase      <= n_phase;
                r_words_left <= n_words_left;
                r_kind       <= n_kind;
                r_cut        <= n_cut;
            end
            if (word_done && n_emit) begin
                r_out_valid <= 1'b1;
                r_out_word  <= word;
                r_out_first <= n_first;
                r_out_last  <= n_last;
                r_out_kind  <= n_kind;
                r_out_cut   <= n_out_cut;
            end else if (o_word.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_word.valid      = r_out_valid;
    assign o_word.frame_word = r_out_word;
    assign o_word.first_word = r_out_first;
    assign o_word.last_word  = r_out_last;
    assign o_word.sync_kind  = r_out_kind;
    assign o_word.cut_error  = r_out_cut;

endmodule

### hw/rtl/slwd_checker.sv
// port-level checks of the deframer and the bind that attaches them
// depends on slwd_pkg and sync_length_word_deframer
module slwd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [slwd_pkg::WORD_W-1:0]  i_frame_word,
    input logic                         i_first_word,
    input logic                         i_last_word,
    input logic                         i_cut_error
);

    // a stalled word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_frame_word))
        else $error("output word changed while stalled");

    // cut flag only on the closing word
    a_cut_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_cut_error |-> i_last_word)
        else $error("cut_error on a word that does not end the frame");

    // a frame has at least sync and length words
    a_first_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_first_word |-> !i_last_word)
        else $error("sync word marked as last");

    // the input side never waits on an empty output register
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

endmodule

bind sync_length_word_deframer slwd_checker u_slwd_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_byte.ready),
    .i_out_valid  (o_word.valid),
    .i_out_ready  (o_word.ready),
    .i_frame_word (o_word.frame_word),
    .i_first_word (o_word.first_word),
    .i_last_word  (o_word.last_word),
    .i_cut_error  (o_word.cut_error)
);
